// ===== rtl/greedy_box_suppression_unit_assert.svh =====
// Assertion macros shared by the box suppression RTL.
`ifndef GREEDY_BOX_SUPPRESSION_UNIT_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define GBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GBS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/gbs_pkg.sv =====
// Shared constants and types of the greedy box suppression block.
`default_nettype none

package gbs_pkg;

    localparam int DEF_MAX_KEPT   = 64;
    localparam int DEF_COORD_BITS = 12;

    localparam int               THR_W       = 16;
    localparam logic [THR_W-1:0] THR_RESET   = 16'd32768;
    localparam int               FRAC_BITS   = 16;
    localparam int               SLOT_W      = 6;
    localparam int               OUT_TDATA_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_READ,
        ST_INTER,
        ST_UNION,
        ST_SCALE,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_AREA,
        OP_INTER,
        OP_UNION,
        OP_SCALE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
        logic check;
    } t_unit_ctl;

    typedef struct packed {
        logic hit;
        logic suppress;
    } t_unit_sts;

endpackage

`default_nettype wire

// ===== rtl/gbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                             i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/gbs_iou_unit.sv =====
// Shared multiplier datapath for box area, overlap and the ratio test.
`default_nettype none

module gbs_iou_unit #(
    parameter int COORD_BITS = gbs_pkg::DEF_COORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gbs_pkg::t_unit_ctl            i_ctl,
    input  wire logic [gbs_pkg::THR_W-1:0]     i_thr,
    input  wire logic [4*COORD_BITS-1:0]       i_new_box,
    input  wire logic [4*COORD_BITS-1:0]       i_kept_box,
    input  wire logic [2*COORD_BITS:0]         i_kept_area,
    output logic      [2*COORD_BITS:0]         o_area,
    output gbs_pkg::t_unit_sts                 o_sts
);
    import gbs_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int AW  = 2 * CW + 1;
    localparam int UW  = AW + 2;
    localparam int MBW = THR_W + 1;
    localparam int PW  = UW + MBW;

    logic signed [CW-1:0]  nx1, ny1, nx2, ny2;
    logic signed [CW-1:0]  kx1, ky1, kx2, ky2;
    logic signed [CW-1:0]  min_x2, max_x1, min_y2, max_y1;
    logic signed [DW-1:0]  ndx, ndy, ovx, ovy;
    logic                  disjoint;
    logic signed [UW-1:0]  mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [PW-1:0]  lhs;
    logic                  hit;

    logic signed [AW-1:0]  r_area;
    logic signed [AW-1:0]  r_inter;
    logic signed [UW-1:0]  r_union;
    logic signed [PW-1:0]  r_scaled;
    logic                  r_suppress;

    assign nx1 = i_new_box[CW-1:0];
    assign ny1 = i_new_box[2*CW-1:CW];
    assign nx2 = i_new_box[3*CW-1:2*CW];
    assign ny2 = i_new_box[4*CW-1:3*CW];
    assign kx1 = i_kept_box[CW-1:0];
    assign ky1 = i_kept_box[2*CW-1:CW];
    assign kx2 = i_kept_box[3*CW-1:2*CW];
    assign ky2 = i_kept_box[4*CW-1:3*CW];

    always_comb begin
        ndx      = DW'(nx2) - DW'(nx1);
        ndy      = DW'(ny2) - DW'(ny1);
        min_x2   = (nx2 < kx2) ? nx2 : kx2;
        max_x1   = (nx1 > kx1) ? nx1 : kx1;
        min_y2   = (ny2 < ky2) ? ny2 : ky2;
        max_y1   = (ny1 > ky1) ? ny1 : ky1;
        ovx      = DW'(min_x2) - DW'(max_x1);
        ovy      = DW'(min_y2) - DW'(max_y1);
        disjoint = (nx1 > kx2) || (nx2 < kx1) || (ny1 > ky2) || (ny2 < ky1);

        unique case (i_ctl.op)
            OP_AREA: begin
                mul_a = UW'(ndx);
                mul_b = MBW'(ndy);
            end
            OP_INTER: begin
                mul_a = UW'(ovx);
                mul_b = MBW'(ovy);
            end
            OP_SCALE: begin
                mul_a = r_union;
                mul_b = signed'({1'b0, i_thr});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign lhs = signed'({(PW - FRAC_BITS)'(r_inter), {FRAC_BITS{1'b0}}});
    assign hit = !r_union[UW-1] && (r_union != '0) && (lhs > r_scaled);

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_AREA:  r_area   <= mul_p[AW-1:0];
            OP_INTER: r_inter  <= disjoint ? '0 : mul_p[AW-1:0];
            OP_UNION: r_union  <= UW'(r_area) + UW'(signed'(i_kept_area)) - UW'(r_inter);
            OP_SCALE: r_scaled <= mul_p;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppress <= 1'b0;
        end else if (i_ctl.start) begin
            r_suppress <= 1'b0;
        end else if (i_ctl.check && hit) begin
            r_suppress <= 1'b1;
        end
    end

    assign o_area         = r_area;
    assign o_sts.hit      = hit;
    assign o_sts.suppress = r_suppress;

endmodule

`default_nettype wire

// ===== rtl/greedy_box_suppression_unit.sv =====
// Top level of the greedy box suppression block: sequencer, kept list and ports.
//
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: left, top, right, bottom edge; tuser: frame_start
//  m_axis   | out       | tdata: keep, kept_slot, list_overflow
//  cfg      | in        | i_cfg_wr_data: iou_threshold, written when i_cfg_wr_en
//
// An item holds the block from acceptance until the input is ready again: it is compared
// with the kept boxes in turn, up to and including the first suppressing one (at most
// MAX_KEPT), and its result then waits in ST_DONE until the output register is free.
// Each comparison walks one kept-list RAM read, two passes through the one multiplier,
// a union sum and a compare.
// Reset clears the kept count, the state and the output valid flag, and sets the threshold to 0.5.
// A result waiting in the output register does not block the next item; only a second
// finished result waits for it.
`default_nettype none

module greedy_box_suppression_unit #(
    parameter int MAX_KEPT   = gbs_pkg::DEF_MAX_KEPT,
    parameter int COORD_BITS = gbs_pkg::DEF_COORD_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_wr_en,
    input  wire logic [gbs_pkg::THR_W-1:0]               i_cfg_wr_data,
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // left_edge, top_edge, right_edge, bottom_edge
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // frame_start
    input  wire logic [0:0]                              s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // keep, kept_slot, list_overflow
    output logic [gbs_pkg::OUT_TDATA_W-1:0]              m_axis_tdata
);
    import gbs_pkg::*;

    `include "greedy_box_suppression_unit_assert.svh"

    localparam int BOX_W  = 4 * COORD_BITS;
    localparam int AREA_W = 2 * COORD_BITS + 1;
    localparam int ROW_W  = BOX_W + AREA_W;
    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int SLOT_X = CNT_W + SLOT_W;

    t_state                  r_state, n_state;
    logic [BOX_W-1:0]        r_box;
    logic [THR_W-1:0]        r_thr;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_mvalid, n_mvalid;
    logic [OUT_TDATA_W-1:0]  r_mdata, n_mdata;

    t_unit_ctl               uctl;
    t_unit_sts               usts;
    logic [AREA_W-1:0]       new_area;
    logic [ROW_W-1:0]        rd_row;
    logic                    ram_we;
    logic                    accept;
    logic                    out_free;
    logic                    full;
    logic [SLOT_X-1:0]       slot_x;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_mvalid || m_axis_tready;
    assign full     = (r_count == CNT_W'(MAX_KEPT));
    assign slot_x   = SLOT_X'(r_count);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_mvalid      = r_mvalid && !m_axis_tready;
        n_mdata       = r_mdata;
        uctl.op       = OP_NONE;
        uctl.start    = 1'b0;
        uctl.check    = 1'b0;
        ram_we        = 1'b0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    uctl.start = 1'b1;
                    n_idx      = '0;
                    if (s_axis_tuser[0]) begin
                        n_count = '0;
                    end
                    n_state = ST_AREA;
                end
            end
            ST_AREA: begin
                uctl.op = OP_AREA;
                n_state = (r_count != '0) ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                n_state = ST_INTER;
            end
            ST_INTER: begin
                uctl.op = OP_INTER;
                n_state = ST_UNION;
            end
            ST_UNION: begin
                uctl.op = OP_UNION;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                uctl.op = OP_SCALE;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                uctl.check = 1'b1;
                n_idx      = r_idx + 1'b1;
                if (usts.hit || (n_idx >= r_count)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_mvalid = 1'b1;
                    if (usts.suppress) begin
                        n_mdata = '0;
                    end else if (full) begin
                        n_mdata = {1'b1, {SLOT_W{1'b0}}, 1'b1};
                    end else begin
                        n_mdata = {1'b0, slot_x[SLOT_W-1:0], 1'b1};
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_mvalid <= 1'b0;
            r_thr    <= THR_RESET;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_mvalid <= n_mvalid;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mdata <= n_mdata;
        if (accept) begin
            r_box <= s_axis_tdata[BOX_W-1:0];
        end
    end

    gbs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data ({new_area, r_box}),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_row)
    );

    gbs_iou_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (uctl),
        .i_thr       (r_thr),
        .i_new_box   (r_box),
        .i_kept_box  (rd_row[BOX_W-1:0]),
        .i_kept_area (rd_row[ROW_W-1:BOX_W]),
        .o_area      (new_area),
        .o_sts       (usts)
    );

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    `GBS_ASSERT(a_count_bound, r_count <= CNT_W'(MAX_KEPT), "Kept count exceeds list size.")
    `GBS_ASSERT(a_read_in_range, (r_state == ST_READ) |-> (r_idx < r_count),
        "Read past kept list.")
    `GBS_ASSERT(a_accept_to_area, accept |=> (r_state == ST_AREA),
        "Accepted item skipped area.")
    `GBS_ASSERT(a_suppress_no_store,
        (r_state == ST_DONE && usts.suppress) |=> $stable(r_count),
        "Suppressed box was stored.")
    `GBS_ASSERT_RST(a_reset_clears,
        !i_rst_n |=> (r_count == '0 && !r_mvalid && r_state == ST_IDLE),
        "Reset did not clear control state.")

endmodule

`default_nettype wire
